// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

    // Classified input character handed from the front to the back
    typedef struct packed {
        logic       is_colon;
        logic       is_hex;
        logic [3:0] nibble;
    } tok_t;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_COLON,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_UPPER,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic CAUSE_DIGIT = 1'b0;
    localparam logic CAUSE_ADDR  = 1'b1;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_ULBA   = 8'h04;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/ihex_front.sv =====
module ihex_front
    import ihex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    output logic       tok_valid,
    input  logic       tok_ready,
    output tok_t       tok
);

    logic valid_reg;
    logic valid_next;
    tok_t tok_reg;
    tok_t tok_next;
    logic accept;

    // Classify the character: colon, hex digit value, or anything else
    always_comb begin
        tok_next          = '0;
        tok_next.is_colon = (s_char_code == CHAR_COLON);
        if (s_char_code >= 8'h30 && s_char_code <= 8'h39) begin
            tok_next.is_hex = 1'b1;
            tok_next.nibble = s_char_code[3:0];
        end else if ((s_char_code >= 8'h61 && s_char_code <= 8'h66) ||
                     (s_char_code >= 8'h41 && s_char_code <= 8'h46)) begin
            tok_next.is_hex = 1'b1;
            tok_next.nibble = 4'(s_char_code[2:0] + 3'd1) + 4'd8;
        end
    end

    // Take a transaction whenever the stage is empty or draining this cycle
    assign s_ready   = !valid_reg || tok_ready;
    assign accept    = s_valid && s_ready;
    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (tok_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tok_reg <= tok_next;
        end
    end

endmodule

// ===== rtl/ihex_queue.sv =====
module ihex_queue
    import ihex_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  tok_t push_tok,
    output logic pop_valid,
    input  logic pop_ready,
    output tok_t pop_tok
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    tok_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wptr_reg;
    logic [PTR_BITS-1:0] wptr_next;
    logic [PTR_BITS-1:0] rptr_reg;
    logic [PTR_BITS-1:0] rptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = entry_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_tok;
        end
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count over depth");

    // Count advances on a push without a pop
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/ihex_back.sv =====
module ihex_back
    import ihex_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   tok_valid,
    output logic                   tok_ready,
    input  tok_t                   tok,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_data_byte,
    output logic [OFFSET_BITS-1:0] m_byte_offset,
    output logic                   m_error_cause
);

    phase_t                 phase_reg, phase_next;
    logic                   second_reg, second_next;
    logic [3:0]             hnib_reg, hnib_next;
    logic                   fbi_reg, fbi_next;
    logic [7:0]             len_reg, len_next;
    logic [15:0]            alo_reg, alo_next;
    logic [15:0]            ahi_reg, ahi_next;
    logic [OFFSET_BITS-1:0] emitted_reg, emitted_next;
    logic                   halted_reg, halted_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg, kind_next;
    logic [7:0]             data_reg, data_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic                   cause_reg, cause_next;

    logic                   pop;
    logic                   res_load;
    logic [7:0]             byte_val;
    logic [7:0]             len_upd;
    logic [15:0]            ahi_upd;
    logic                   start_data;

    // Pop a token whenever the output slot is free or being emptied
    assign tok_ready = !out_valid_reg || m_ready;
    assign pop       = tok_valid && tok_ready;
    assign byte_val  = {hnib_reg, tok.nibble};
    assign len_upd   = len_reg - 8'd2;
    assign ahi_upd   = {ahi_reg[15:8], byte_val};

    // Decode one token per cycle while the output slot is free or being emptied
    always_comb begin
        phase_next   = phase_reg;
        second_next  = second_reg;
        hnib_next    = hnib_reg;
        fbi_next     = fbi_reg;
        len_next     = len_reg;
        alo_next     = alo_reg;
        ahi_next     = ahi_reg;
        emitted_next = emitted_reg;
        halted_next  = halted_reg;
        res_load     = 1'b0;
        kind_next    = KIND_DATA;
        data_next    = '0;
        off_next     = '0;
        cause_next   = CAUSE_DIGIT;
        start_data   = 1'b0;

        if (pop && !halted_reg) begin
            unique case (phase_reg)
                PH_DONE: begin
                end
                PH_COLON: begin
                    if (tok.is_colon) begin
                        phase_next  = PH_LEN;
                        second_next = 1'b0;
                    end else begin
                        halted_next = 1'b1;
                        res_load    = 1'b1;
                        kind_next   = KIND_ERR;
                        cause_next  = CAUSE_DIGIT;
                    end
                end
                PH_SKIP: begin
                    if (tok.is_colon) begin
                        phase_next  = PH_LEN;
                        second_next = 1'b0;
                    end
                end
                default: begin
                    if (!tok.is_hex) begin
                        halted_next = 1'b1;
                        res_load    = 1'b1;
                        kind_next   = KIND_ERR;
                        cause_next  = CAUSE_DIGIT;
                    end else if (!second_reg) begin
                        hnib_next   = tok.nibble;
                        second_next = 1'b1;
                    end else begin
                        second_next = 1'b0;
                        unique case (phase_reg)
                            PH_LEN: begin
                                len_next   = byte_val;
                                fbi_next   = 1'b0;
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR: begin
                                if (!fbi_reg) begin
                                    alo_next = {byte_val, 8'h00};
                                    fbi_next = 1'b1;
                                end else begin
                                    alo_next   = {alo_reg[15:8], byte_val};
                                    fbi_next   = 1'b0;
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                if (byte_val == REC_EOF) begin
                                    phase_next = PH_DONE;
                                    res_load   = 1'b1;
                                    kind_next  = KIND_END;
                                end else if (byte_val == REC_ULBA) begin
                                    fbi_next   = 1'b0;
                                    phase_next = PH_UPPER;
                                end else begin
                                    start_data = 1'b1;
                                end
                            end
                            PH_UPPER: begin
                                if (!fbi_reg) begin
                                    ahi_next = {byte_val, 8'h00};
                                    fbi_next = 1'b1;
                                end else begin
                                    ahi_next   = ahi_upd;
                                    fbi_next   = 1'b0;
                                    len_next   = len_upd;
                                    start_data = 1'b1;
                                end
                            end
                            PH_DATA: begin
                                res_load     = 1'b1;
                                kind_next    = KIND_DATA;
                                data_next    = byte_val;
                                off_next     = emitted_reg;
                                emitted_next = emitted_reg + 1'b1;
                                len_next     = len_reg - 8'd1;
                                if (len_reg == 8'd1) begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            default: begin
                            end
                        endcase

                        // Check contiguity before the data of a record
                        if (start_data) begin
                            if ({ahi_next, alo_reg} != 32'(emitted_reg)) begin
                                halted_next = 1'b1;
                                res_load    = 1'b1;
                                kind_next   = KIND_ERR;
                                cause_next  = CAUSE_ADDR;
                            end else begin
                                phase_next = (len_next != 8'd0) ? PH_DATA : PH_SKIP;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Hold the result until the sink takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COLON;
            second_reg    <= 1'b0;
            hnib_reg      <= '0;
            fbi_reg       <= 1'b0;
            len_reg       <= '0;
            alo_reg       <= '0;
            ahi_reg       <= '0;
            emitted_reg   <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            second_reg    <= second_next;
            hnib_reg      <= hnib_next;
            fbi_reg       <= fbi_next;
            len_reg       <= len_next;
            alo_reg       <= alo_next;
            ahi_reg       <= ahi_next;
            emitted_reg   <= emitted_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            off_reg   <= off_next;
            cause_reg <= cause_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = kind_reg;
    assign m_data_byte   = data_reg;
    assign m_byte_offset = off_reg;
    assign m_error_cause = cause_reg;

    // No result once halted or past the end record
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg || phase_reg == PH_DONE) |-> !res_load)
        else $error("result after halt or end record");

    // An error result always halts the decoder
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && kind_next == KIND_ERR) |=> halted_reg)
        else $error("error without halt");

    // Non-data results carry zero payload
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg != KIND_DATA) |-> (data_reg == '0 && off_reg == '0))
        else $error("non-data result with payload");

    // Emitted count advances only on data results
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (emitted_reg != $past(emitted_reg)) |-> $past(res_load && kind_next == KIND_DATA))
        else $error("byte count moved without a data result");

endmodule

// ===== rtl/intel_hex_record_decoder_top.sv =====
// Intel HEX record decoder. Feed one ASCII character of the image per
// transaction on the s_ channel; results leave on the m_ channel: a data byte
// with its image offset, one end-of-image marker, or one error, after which
// the block stays silent until reset. A character is taken every cycle
// when the sink keeps up: the front stage classifies it, a two-entry queue
// buffers it, and the back-end decoder retires one character per cycle into
// an output register. Checksums are not verified; they are skipped with line
// ends.
module intel_hex_record_decoder_top
    import ihex_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_char_code,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_data_byte,
    output logic [OFFSET_BITS-1:0] m_byte_offset,
    output logic                   m_error_cause
);

    logic fr_valid;
    logic fr_ready;
    tok_t fr_tok;
    logic bk_valid;
    logic bk_ready;
    tok_t bk_tok;

    ihex_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .tok_valid   (fr_valid),
        .tok_ready   (fr_ready),
        .tok         (fr_tok)
    );

    ihex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_tok   (fr_tok),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_tok    (bk_tok)
    );

    ihex_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tok_valid     (bk_valid),
        .tok_ready     (bk_ready),
        .tok           (bk_tok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_byte_offset (m_byte_offset),
        .m_error_cause (m_error_cause)
    );

endmodule
